[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// types, codes and sizes shared by the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int TOTAL_W  = 7;

	localparam logic [2:0] ACT_INSERT  = 3'd0;
	localparam logic [2:0] ACT_MODIFY  = 3'd1;
	localparam logic [2:0] ACT_EXTRACT = 3'd2;
	localparam logic [2:0] ACT_PEEK    = 3'd3;
	localparam logic [2:0] ACT_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} spq_in_t;

	typedef struct packed {
		logic signed [31:0]   front_value;
		logic [TOTAL_W-1:0]   entry_total;
		logic [1:0]           status;
	} spq_out_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_HEAD,
		S_DROP,
		S_INS_INIT,
		S_INS,
		S_INS_HEAD,
		S_FRONT,
		S_DONE
	} spq_state_t;

endpackage

[rtl/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// sequencer that scans, shifts and places entries one per cycle
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  spq_in_t  in_item,
	output logic     res_valid,
	input  logic     res_take,
	output spq_out_t res,
	output logic     wr_en,
	output addr_t    wr_addr,
	output entry_t   wr_data,
	output addr_t    rd_addr,
	input  entry_t   rd_data
);

	spq_state_t  state_q, state_d;
	spq_in_t     op_q;
	cnt_t        count_q, cur_q, pidx_q;
	logic        pend_q;
	logic signed [31:0] front_q;
	logic [1:0]  status_q;

	cnt_t   nxt_idx, prv_idx, cnt_m1;
	logic   lower, match, last, full, empty, cur_end, keep_head;
	entry_t new_entry;

	assign nxt_idx   = pidx_q + cnt_t'(1);
	assign prv_idx   = pidx_q - cnt_t'(1);
	assign cnt_m1    = count_q - cnt_t'(1);
	assign lower     = rd_data.prio < op_q.item_priority;
	assign match     = rd_data.value == op_q.item_value;
	assign last      = pidx_q == cnt_m1;
	assign full      = count_q == cnt_t'(CAPACITY);
	assign empty     = count_q == '0;
	assign cur_end   = cur_q >= count_q;
	assign keep_head = (count_q == cnt_t'(1)) || (rd_data.prio <= op_q.item_priority);
	assign new_entry = '{value: op_q.item_value, prio: op_q.item_priority};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_item.action)
						ACT_INSERT:             state_d = full ? S_DONE : S_INS_INIT;
						ACT_MODIFY:             state_d = empty ? S_DONE : S_FIND;
						ACT_EXTRACT, ACT_PEEK:  state_d = empty ? S_DONE : S_FRONT;
						default:                state_d = S_DONE;
					endcase
				end
			end
			S_FIND: begin
				if (pend_q) begin
					if (match) begin
						state_d = (pidx_q == '0) ? S_HEAD : S_DROP;
					end else if (last) begin
						state_d = S_DONE;
					end
				end
			end
			S_HEAD: state_d = keep_head ? S_DONE : S_DROP;
			S_DROP: begin
				if ((!pend_q && cur_end) || (pend_q && last)) begin
					state_d = (op_q.action == ACT_MODIFY) ? S_INS_INIT : S_DONE;
				end
			end
			S_INS_INIT: state_d = empty ? S_DONE : S_INS;
			S_INS: begin
				if (pend_q) begin
					if (!lower) begin
						state_d = S_DONE;
					end else if (pidx_q == '0) begin
						state_d = S_INS_HEAD;
					end
				end
			end
			S_INS_HEAD: state_d = S_DONE;
			S_FRONT:    state_d = (op_q.action == ACT_EXTRACT) ? S_DROP : S_DONE;
			S_DONE:     state_d = res_take ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory ports and handshake
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_entry;
		rd_addr = (state_q == S_IDLE) ? '0 : cur_q[ADDR_W-1:0];
		case (state_q)
			S_HEAD: wr_en = keep_head;
			S_DROP: begin
				wr_en   = pend_q;
				wr_addr = prv_idx[ADDR_W-1:0];
				wr_data = rd_data;
			end
			S_INS_INIT: wr_en = empty;
			S_INS: begin
				wr_en   = pend_q;
				wr_addr = nxt_idx[ADDR_W-1:0];
				wr_data = lower ? rd_data : new_entry;
			end
			S_INS_HEAD: wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = '{front_value: front_q, entry_total: TOTAL_W'(count_q), status: status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pend_q <= 1'b0;
						if (in_item.action == ACT_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_FIND: begin
					if (!pend_q || (!match && !last)) begin
						pend_q <= 1'b1;
					end else if (match && pidx_q != '0) begin
						pend_q <= 1'b0;
					end
				end
				S_HEAD: pend_q <= 1'b0;
				S_DROP: begin
					if (!pend_q) begin
						if (cur_end) begin
							count_q <= cnt_m1;
						end else begin
							pend_q <= 1'b1;
						end
					end else if (last) begin
						count_q <= cnt_m1;
					end
				end
				S_INS_INIT: begin
					pend_q <= 1'b0;
					if (empty) begin
						count_q <= count_q + cnt_t'(1);
					end
				end
				S_INS: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (!lower) begin
						count_q <= count_q + cnt_t'(1);
					end
				end
				S_INS_HEAD: count_q <= count_q + cnt_t'(1);
				S_FRONT:    pend_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q     <= in_item;
					front_q  <= '0;
					cur_q    <= '0;
					status_q <= ST_OK;
					case (in_item.action)
						ACT_INSERT: if (full) status_q <= ST_FULL;
						ACT_MODIFY, ACT_EXTRACT, ACT_PEEK: if (empty) status_q <= ST_EMPTY;
						default: ;
					endcase
				end
			end
			S_FIND: begin
				if (!pend_q || (!match && !last)) begin
					pidx_q <= cur_q;
					cur_q  <= cur_q + cnt_t'(1);
				end else if (match) begin
					cur_q <= nxt_idx;
				end else begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_HEAD: cur_q <= cnt_t'(1);
			S_DROP: begin
				if ((!pend_q && !cur_end) || (pend_q && !last)) begin
					pidx_q <= cur_q;
					cur_q  <= cur_q + cnt_t'(1);
				end
			end
			S_INS_INIT: cur_q <= cnt_m1;
			S_INS: begin
				if (!pend_q || lower) begin
					pidx_q <= cur_q;
					cur_q  <= cur_q - cnt_t'(1);
				end
			end
			S_FRONT: begin
				front_q <= rd_data.value;
				cur_q   <= cnt_t'(1);
			end
			default: ;
		endcase
	end

endmodule

[rtl/sorted_priority_queue_core.sv]
// insert: one stored entry moved per cycle
// modify key: search, close gap, place
// extract: read the front, then close the gap; a missed modify key scans every entry
// peek, clear, empty and full cases need no scan; one item at a time
// the result waits in an output register while the next item is taken
// asynchronous reset empties the queue; entries themselves are not cleared
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded max-priority queue kept sorted by descending priority
// ----------------------------------------------------------------------------
module sorted_priority_queue_core import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  spq_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_out_t out_item
);

	logic     res_valid, res_take, wr_en;
	spq_out_t res;
	addr_t    wr_addr, rd_addr;
	entry_t   wr_data, rd_data;
	logic     out_valid_q;
	spq_out_t out_q;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	spq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// port level checks for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker import spq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input spq_in_t  in_item,
	input logic     out_valid,
	input logic     out_ready,
	input spq_out_t out_item
);

	logic in_seen;
	assign in_seen = in_item.action == ACT_INSERT || in_valid;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_seen && out_item.status != ST_OK |-> out_item.front_value == '0)
		else $error("error result carries a value");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_EMPTY |-> out_item.entry_total == '0)
		else $error("empty status with entries held");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FULL |-> out_item.entry_total == TOTAL_W'(CAPACITY))
		else $error("full status below capacity");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

[tb/sv/sorted_priority_queue_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// drives insert, modify key, extract, peek, clear and undefined action items into the queue,
// predicts each result from a software copy of the sorted entries and
// compares every result field with the oldest prediction
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;
	import spq_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	spq_in_t  in_item;
	logic     out_valid;
	logic     out_ready;
	spq_out_t out_item;

	spq_in_t  pending_items[$];
	spq_out_t expected_results[$];

	logic signed [31:0] q_val[CAPACITY];
	logic signed [31:0] q_pri[CAPACITY];
	int                 q_count;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  send_hold;
	int  n_fail;
	int  n_items;
	int  n_results;
	bit  stim_done;
	int  n_act[8];

	sorted_priority_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int queue_slot(logic signed [31:0] p);
		int i;
		i = 0;
		while (i < q_count && q_pri[i] >= p)
			i++;
		return i;
	endfunction

	function automatic void queue_place(int pos, logic signed [31:0] v, logic signed [31:0] p);
		int i;
		for (i = q_count; i > pos; i--) begin
			q_val[i] = q_val[i-1];
			q_pri[i] = q_pri[i-1];
		end
		q_val[pos] = v;
		q_pri[pos] = p;
		q_count++;
	endfunction

	function automatic void queue_drop(int pos);
		int i;
		for (i = pos; i + 1 < q_count; i++) begin
			q_val[i] = q_val[i+1];
			q_pri[i] = q_pri[i+1];
		end
		q_count--;
	endfunction

	function automatic spq_out_t queue_predict(spq_in_t it);
		spq_out_t r;
		int i;
		r.front_value = '0;
		r.status = ST_OK;
		case (it.action)
			ACT_INSERT: begin
				if (q_count >= CAPACITY)
					r.status = ST_FULL;
				else
					queue_place(queue_slot(it.item_priority), it.item_value, it.item_priority);
			end
			ACT_MODIFY: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					i = 0;
					while (i < q_count && q_val[i] != it.item_value)
						i++;
					if (i >= q_count) begin
						r.status = ST_NOT_FOUND;
					end else if (i == 0 && (q_count == 1 || it.item_priority >= q_pri[1])) begin
						q_pri[0] = it.item_priority;
					end else begin
						queue_drop(i);
						queue_place(queue_slot(it.item_priority), it.item_value,
							it.item_priority);
					end
				end
			end
			ACT_EXTRACT: begin
				if (q_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.front_value = q_val[0];
					queue_drop(0);
				end
			end
			ACT_PEEK: begin
				if (q_count == 0)
					r.status = ST_EMPTY;
				else
					r.front_value = q_val[0];
			end
			ACT_CLEAR: q_count = 0;
			default: ;
		endcase
		r.entry_total = q_count[TOTAL_W-1:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(queue_predict(in_item));
				n_items++;
				n_act[in_item.action]++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && !send_hold &&
				    $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no item pending: %p", out_item);
					n_fail++;
				end else begin
					spq_out_t e;
					e = expected_results.pop_front();
					if (out_item.front_value !== e.front_value) begin
						$error("front_value expected %0d actual %0d", e.front_value,
							out_item.front_value);
						n_fail++;
					end
					if (out_item.entry_total !== e.entry_total) begin
						$error("entry_total expected %0d actual %0d", e.entry_total,
							out_item.entry_total);
						n_fail++;
					end
					if (out_item.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, out_item.status);
						n_fail++;
					end
				end
				n_results++;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic spq_in_t mk(logic [2:0] a, logic signed [31:0] v, logic signed [31:0] p);
		spq_in_t it;
		it.action = a;
		it.item_value = v;
		it.item_priority = p;
		return it;
	endfunction

	// values inserted since the last clear, tracked on the stimulus side so modify keys usually hit
	logic signed [31:0] known_vals[$];

	function automatic logic signed [31:0] rand_prio();
		case ($urandom_range(3))
			0: return $signed($urandom_range(7)) - 4;
			1: return 32'sh7fffffff - $urandom_range(1);
			2: return 32'sh80000000 + $urandom_range(1);
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic spq_in_t rand_item();
		int k;
		logic signed [31:0] v;
		k = $urandom_range(99);
		if (k < 40) begin
			v = ($urandom_range(3) == 0) ? $signed($urandom()) : $signed($urandom_range(40));
			known_vals.push_back(v);
			return mk(ACT_INSERT, v, rand_prio());
		end else if (k < 65) begin
			if (known_vals.size() > 0 && $urandom_range(4) != 0)
				v = known_vals[$urandom_range(known_vals.size() - 1)];
			else
				v = $signed($urandom());
			return mk(ACT_MODIFY, v, rand_prio());
		end else if (k < 85) begin
			return mk(ACT_EXTRACT, $signed($urandom()), $signed($urandom()));
		end else if (k < 96) begin
			return mk(ACT_PEEK, $signed($urandom()), $signed($urandom()));
		end else if (k < 98) begin
			known_vals.delete();
			return mk(ACT_CLEAR, $signed($urandom()), $signed($urandom()));
		end else begin
			return mk(3'($urandom_range(7, 5)), $signed($urandom()), $signed($urandom()));
		end
	endfunction

	task automatic wait_drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int ph;
		int i;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_hold = 1'b0;
		n_fail = 0;
		n_items = 0;
		n_results = 0;
		stim_done = 1'b0;
		q_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, extremes, ties, front modify, full, clear
		pending_items.push_back(mk(ACT_EXTRACT, 0, 0));
		pending_items.push_back(mk(ACT_PEEK, 0, 0));
		pending_items.push_back(mk(ACT_MODIFY, 1, 1));
		pending_items.push_back(mk(ACT_INSERT, 32'sh7fffffff, 32'sh80000000));
		pending_items.push_back(mk(ACT_INSERT, 32'sh80000000, 32'sh7fffffff));
		pending_items.push_back(mk(ACT_INSERT, 5, 32'sh7fffffff));
		pending_items.push_back(mk(ACT_INSERT, -1, 0));
		pending_items.push_back(mk(ACT_MODIFY, 99, 3));
		pending_items.push_back(mk(ACT_MODIFY, 32'sh80000000, 32'sh7fffffff));
		pending_items.push_back(mk(ACT_MODIFY, 32'sh80000000, -7));
		pending_items.push_back(mk(ACT_MODIFY, 5, 1));
		pending_items.push_back(mk(ACT_MODIFY, 32'sh7fffffff, 32'sh7fffffff));
		pending_items.push_back(mk(ACT_PEEK, -1, -1));
		pending_items.push_back(mk(3'd5, -1, -1));
		pending_items.push_back(mk(3'd7, 0, 0));
		pending_items.push_back(mk(ACT_EXTRACT, -1, -1));
		pending_items.push_back(mk(ACT_CLEAR, 0, 0));
		for (i = 0; i < CAPACITY + 1; i++)
			pending_items.push_back(mk(ACT_INSERT, i, i % 3));
		pending_items.push_back(mk(ACT_MODIFY, 0, 2));
		pending_items.push_back(mk(ACT_PEEK, 0, 0));
		pending_items.push_back(mk(ACT_CLEAR, 0, 0));
		wait_drain();

		// pause the sender once the queue has drained
		send_hold = 1'b1;
		repeat (20) @(posedge clk);
		send_hold = 1'b0;

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			for (i = 0; i < 400; i++)
				pending_items.push_back(rand_item());
			wait_drain();
		end
		repeat (200) @(posedge clk);
		stim_done = 1'b1;
		$display("covered %0d items: insert %0d, modify %0d, extract %0d, peek %0d, clear %0d",
			n_items, n_act[0], n_act[1], n_act[2], n_act[3], n_act[4]);
		$display("idle phases: none, sender, receiver, both; %0d results checked", n_results);
		if (n_fail == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#10000000;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
tb/sv/sorted_priority_queue_core_test.sv
